// ===== hw/rtl/dmv_pkg.sv =====
// dmv_pkg: shared types, constants and the step-size table for the
// delta modulation voice core. No dependencies.
package dmv_pkg;

  localparam logic [3:0]  LEVEL_MID   = 4'd7;
  localparam logic [3:0]  LEVEL_MAX   = 4'hf;
  localparam logic [1:0]  DELTA_START = 2'd2;
  localparam logic [14:0] NOISE_SEED  = 15'h7fff;
  localparam logic [4:0]  DEPTH_FULL  = 5'd16;

  // Register indexes on the config port
  localparam logic [2:0] CFG_DELTA_PATTERN = 3'd0;
  localparam logic [2:0] CFG_VOICED_MODE   = 3'd1;
  localparam logic [2:0] CFG_PITCH_PERIOD  = 3'd2;
  localparam logic [2:0] CFG_DELTA_DEPTH   = 3'd3;

  localparam logic [63:0] PATTERN_RST = 64'd0;
  localparam logic [7:0]  PERIOD_RST  = 8'd22;

  typedef struct packed {
    logic [63:0] delta_pattern;
    logic        voiced_mode;
    logic [7:0]  pitch_period;
    logic [4:0]  delta_depth;
  } cfg_t;

  typedef struct packed {
    logic [3:0] dac_level;
    logic       period_wrap;
  } res_t;

  typedef struct packed {
    logic [1:0] count;
  } q_stat_t;

  // Step size by [row][col]
  function automatic logic [1:0] inc_lookup(input logic [1:0] row, input logic [1:0] col);
    logic [1:0] v;
    v = 2'd0;
    case (row)
      2'd0: v = col[1] ? 2'd1 : 2'd3;
      2'd1: v = col[1] ? 2'd0 : 2'd1;
      2'd2: v = col[1] ? 2'd1 : 2'd0;
      2'd3: v = col[1] ? 2'd3 : 2'd1;
      default: v = 2'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hw/rtl/delta_modulation_voice_core.sv =====
// delta_modulation_voice_core: top level of the 2-bit delta modulation voice.
// Path: an accepted beat is registered, then its tick result is written into the result queue.
// Throughput: one beat per cycle while in_stall is low.
// Reset: synchronous active-low rst_n; registers other than the restart flag and queue
// memory return to their reset values, voice level 7, noise register all ones, result queue empty.
// Depends on dmv_pkg, dmv_cfg_regs, dmv_tick, dmv_out_queue.
module delta_modulation_voice_core import dmv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_restart,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_dac_level,
  output logic        out_period_wrap
);

  cfg_t    cfg;
  res_t    tick_res;
  res_t    q_data;
  q_stat_t q_stat;

  // input register
  logic s1_v_r, s1_restart_r;
  logic in_acc;
  logic pop;
  logic [2:0] occ;

  dmv_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Beats in flight: queue entries plus the input register. Stall whenever
  // the beat accepted now could not find a queue slot next cycle.
  assign pop      = out_valid && !out_stall;
  assign occ      = {1'b0, q_stat.count} + {2'd0, s1_v_r} - {2'd0, pop};
  assign in_stall = occ >= 3'd2;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) s1_restart_r <= in_restart;
  end

  // Tick logic runs on the registered beat and writes straight into the queue.
  dmv_tick u_tick (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .tick_en (s1_v_r),
    .restart (s1_restart_r),
    .res     (tick_res)
  );

  dmv_out_queue u_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_v_r),
    .push_data (tick_res),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (q_data),
    .stat      (q_stat)
  );

  assign out_dac_level   = q_data.dac_level;
  assign out_period_wrap = q_data.period_wrap;

  a_stall_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_v_r)
    else $error("accepted beat lost before the tick stage");

  a_restart_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && s1_restart_r) |-> (tick_res.dac_level == LEVEL_MID &&
                                  !tick_res.period_wrap))
    else $error("restart beat gave a non-center result");

endmodule

// ===== hw/rtl/dmv_cfg_regs.sv =====
// dmv_cfg_regs: configuration register file, write-only port.
// Depends on dmv_pkg.
module dmv_cfg_regs import dmv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output cfg_t        cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delta_pattern <= PATTERN_RST;
      cfg_r.voiced_mode   <= 1'b1;
      cfg_r.pitch_period  <= PERIOD_RST;
      cfg_r.delta_depth   <= DEPTH_FULL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELTA_PATTERN: cfg_r.delta_pattern <= cfg_wdata;
        CFG_VOICED_MODE:   cfg_r.voiced_mode   <= cfg_wdata[0];
        CFG_PITCH_PERIOD:  cfg_r.pitch_period  <= cfg_wdata[7:0];
        CFG_DELTA_DEPTH:   cfg_r.delta_depth   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/dmv_tick.sv =====
// dmv_tick: voice state registers and the one-tick update logic.
// Depends on dmv_pkg.
module dmv_tick import dmv_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic tick_en,
  input  logic restart,
  output res_t res
);

  logic [3:0]  level_r,  level_nxt;
  logic [1:0]  prev_r,   prev_nxt;
  logic [1:0]  quarter_r, quarter_nxt;
  logic [2:0]  step_r,   step_nxt;
  logic [7:0]  pc_r,     pc_nxt;
  logic [14:0] noise_r,  noise_nxt;

  logic        mirror;
  logic        swap;
  logic [2:0]  addr;
  logic [4:0]  idx;
  logic [1:0]  delta;
  logic [1:0]  row, col;
  logic [1:0]  inc_raw, inc;
  logic [6:0]  scaled;
  logic        add;
  logic [3:0]  base, tmp, sat;
  logic [4:0]  sum;
  logic [8:0]  pc_inc;
  logic        wrap;

  always_comb begin
    mirror    = quarter_r[0];
    addr      = mirror ? ~step_r : step_r;
    idx       = {quarter_r, addr};
    noise_nxt = noise_r;
    if (cfg.voiced_mode) begin
      delta = cfg.delta_pattern[{idx, 1'b0} +: 2];
    end else begin
      noise_nxt = {noise_r[0] ^ noise_r[1], noise_r[14:1]};
      delta     = noise_nxt[1:0];
    end

    swap    = cfg.voiced_mode && mirror;
    row     = swap ? prev_r : delta;
    col     = swap ? delta : prev_r;
    inc_raw = inc_lookup(row, col);
    add     = swap ? !prev_r[1] : delta[1];

    // depth scaling in sixteenths, round half up
    scaled = 7'({5'd0, inc_raw} * 7'(cfg.delta_depth)) + 7'd8;
    inc    = (cfg.delta_depth < DEPTH_FULL) ? scaled[5:4] : inc_raw;

    base = (step_r == 3'd0 && quarter_r == 2'd0) ? LEVEL_MID : level_r;
    // subtraction done by complementing around the saturating add
    tmp  = add ? base : ~base;
    sum  = {1'b0, tmp} + {3'd0, inc};
    sat  = sum[4] ? LEVEL_MAX : sum[3:0];

    level_nxt   = add ? sat : ~sat;
    prev_nxt    = delta;
    step_nxt    = step_r + 3'd1;
    quarter_nxt = (step_r == 3'd7) ? quarter_r + 2'd1 : quarter_r;

    pc_inc = {1'b0, pc_r} + 9'd1;
    wrap   = pc_inc >= {1'b0, cfg.pitch_period};
    pc_nxt = pc_inc[7:0];
    if (wrap) begin
      pc_nxt      = 8'd0;
      quarter_nxt = 2'd0;
      step_nxt    = 3'd0;
      prev_nxt    = DELTA_START;
    end

    res.dac_level   = level_nxt;
    res.period_wrap = wrap;
    if (restart) begin
      level_nxt       = LEVEL_MID;
      prev_nxt        = DELTA_START;
      quarter_nxt     = 2'd0;
      step_nxt        = 3'd0;
      pc_nxt          = 8'd0;
      noise_nxt       = noise_r;
      res.dac_level   = LEVEL_MID;
      res.period_wrap = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r   <= LEVEL_MID;
      prev_r    <= DELTA_START;
      quarter_r <= 2'd0;
      step_r    <= 3'd0;
      pc_r      <= 8'd0;
      noise_r   <= NOISE_SEED;
    end else if (tick_en) begin
      level_r   <= level_nxt;
      prev_r    <= prev_nxt;
      quarter_r <= quarter_nxt;
      step_r    <= step_nxt;
      pc_r      <= pc_nxt;
      noise_r   <= noise_nxt;
    end
  end

  a_restart_centers: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_en && restart) |=> (level_r == LEVEL_MID && pc_r == 8'd0 && step_r == 3'd0))
    else $error("restart did not recenter the voice");

  a_wrap_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_en && !restart && wrap) |=> (quarter_r == 2'd0 && step_r == 3'd0 &&
                                       prev_r == DELTA_START))
    else $error("period wrap left counters running");

endmodule

// ===== hw/rtl/dmv_out_queue.sv =====
// dmv_out_queue: two-entry result queue decoupling the tick logic from
// the output stall. Depends on dmv_pkg.
module dmv_out_queue import dmv_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  res_t    push_data,
  input  logic    pop,
  output logic    out_valid,
  output res_t    out_data,
  output q_stat_t stat
);

  res_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

  assign out_valid  = cnt_r != 2'd0;
  assign out_data   = mem_r[rd_ptr_r];
  assign stat.count = cnt_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'd2)
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && cnt_r == 2'd2) |-> pop)
    else $error("push into full result queue");

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for delta_modulation_voice_core, with a predictor of the
// voice tick, a randomly paced beat driver and result monitor, and register phases.
// Depends on dmv_pkg and delta_modulation_voice_core.
module tb_top;
  import dmv_pkg::*;

  // Cycles with no beat moving on either channel before the run is called dead.
  // A correct run idles only for send gaps, result stalls, pipeline latency and register writes.
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned RANDOM_BEATS   = 410;

  // Step size, entry {row, col} at bits 2*{row, col} +: 2.
  // rows: 0 -> 3,3,1,1  1 -> 1,1,0,0  2 -> 0,0,1,1  3 -> 1,1,3,3
  localparam logic [31:0] STEP_BY_ROW_COL = 32'hF550_055F;

  typedef enum logic [1:0] {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_index  = CFG_DELTA_PATTERN;
  logic [63:0] cfg_wdata  = '0;
  logic        in_valid   = 1'b0;
  logic        in_restart = 1'b0;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [3:0]  out_dac_level;
  logic        out_period_wrap;

  delta_modulation_voice_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_restart      (in_restart),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_dac_level   (out_dac_level),
    .out_period_wrap (out_period_wrap)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Voice predictor: own copy of registers and voice state
  // ---------------------------------------------------------------------------
  logic [63:0] pat_cfg;
  logic        voiced_cfg;
  logic [7:0]  period_cfg;
  logic [4:0]  depth_cfg;

  logic [3:0]  lvl_now;
  logic [1:0]  prev_delta;
  logic [1:0]  qtr;
  logic [2:0]  qstep;
  logic [8:0]  tick_count;   // one bit over the period so a lowered period still wraps
  logic [14:0] lfsr;

  res_t        level_expect[$];   // predicted DAC beats, oldest first
  logic        pending[$];        // restart flags not yet handed to the driver
  int          beats_left = 0;    // queued or on the bus, not yet accepted
  int unsigned mismatches = 0;
  pace_t       send_pace = PACE_FULL;
  pace_t       recv_pace = PACE_FULL;

  // note-on: everything but the noise register
  function automatic void voice_clear();
    lvl_now    = LEVEL_MID;
    prev_delta = DELTA_START;
    qtr        = '0;
    qstep      = '0;
    tick_count = '0;
  endfunction

  // One accepted beat -> one expected DAC beat.
  function automatic void predict_beat(input logic restart);
    res_t        r;
    logic [1:0]  delta, row, col;
    logic [2:0]  addr;
    logic [4:0]  slot;
    logic        mirror, raise;
    logic [3:0]  base;
    logic [4:0]  sum;
    int unsigned step;
    mirror        = qtr[0];
    r.period_wrap = 1'b0;
    if (restart) begin
      voice_clear();
      r.dac_level = LEVEL_MID;
    end else begin
      if (voiced_cfg) begin
        // odd quarters walk their eight entries backwards
        addr  = mirror ? 3'd7 - qstep : qstep;
        slot  = {qtr, addr};
        delta = pat_cfg[2 * int'(slot) +: 2];
      end else begin
        lfsr  = {lfsr[0] ^ lfsr[1], lfsr[14:1]};
        delta = lfsr[1:0];
      end
      // mirrored quarters swap the table indices and take direction from the old delta
      if (voiced_cfg && mirror) begin
        row   = prev_delta;
        col   = delta;
        raise = !prev_delta[1];
      end else begin
        row   = delta;
        col   = prev_delta;
        raise = delta[1];
      end
      step = STEP_BY_ROW_COL[2 * int'({row, col}) +: 2];
      if (depth_cfg < DEPTH_FULL) step = (step * depth_cfg + 8) >> 4;
      prev_delta = delta;
      if (qstep == '0 && qtr == '0) lvl_now = LEVEL_MID;
      // fall is a rise on the complemented level, so one clamp at the top serves both
      base = raise ? lvl_now : ~lvl_now;
      sum  = {1'b0, base} + 5'(step);
      if (sum > {1'b0, LEVEL_MAX}) sum = {1'b0, LEVEL_MAX};
      lvl_now = raise ? sum[3:0] : ~sum[3:0];
      if (qstep == 3'd7) qtr = qtr + 2'd1;
      qstep      = qstep + 3'd1;
      tick_count = tick_count + 9'd1;
      if (tick_count >= {1'b0, period_cfg}) begin
        tick_count    = '0;
        qtr           = '0;
        qstep         = '0;
        prev_delta    = DELTA_START;
        r.period_wrap = 1'b1;
      end
      r.dac_level = lvl_now;
    end
    level_expect.push_back(r);
  endfunction

  function automatic int unsigned draw_wait(input pace_t pace);
    case (pace)
      PACE_FULL:  return 0;
      PACE_LIGHT: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
      default:    return $urandom_range(0, 18);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one beat per restart flag, random gap after each
  // ---------------------------------------------------------------------------
  int unsigned send_gap = 0;

  always @(posedge clk) begin : beat_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_beat(in_restart);
        beats_left--;
      end
      // payload only moves once the current beat is gone
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap--;
        end else if (pending.size() != 0) begin
          in_valid   <= 1'b1;
          in_restart <= pending.pop_front();
          send_gap = draw_wait(send_pace);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: check each beat against the oldest prediction, random stalls
  // ---------------------------------------------------------------------------
  int unsigned recv_wait = 0;

  always @(posedge clk) begin : result_monitor
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (level_expect.size() == 0) begin
          $error("result beat with none expected: dac_level %0d period_wrap %0d",
                 out_dac_level, out_period_wrap);
          mismatches++;
        end else begin
          want = level_expect.pop_front();
          if (out_dac_level !== want.dac_level) begin
            $error("dac_level: expected %0d, got %0d", want.dac_level, out_dac_level);
            mismatches++;
          end
          if (out_period_wrap !== want.period_wrap) begin
            $error("period_wrap: expected %0d, got %0d", want.period_wrap, out_period_wrap);
            mismatches++;
          end
        end
        recv_wait = draw_wait(recv_pace);
      end
      // stall also runs with nothing offered, so it lands on every pipeline phase
      if (recv_wait != 0) begin
        out_stall <= 1'b1;
        recv_wait--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: no beat on either channel for too long means a hang
  // ---------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin : watchdog
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("delta_modulation_voice_core: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DELTA_PATTERN: pat_cfg    = val;
      CFG_VOICED_MODE:   voiced_cfg = val[0];
      CFG_PITCH_PERIOD:  period_cfg = val[7:0];
      CFG_DELTA_DEPTH:   depth_cfg  = val[4:0];
      default: ;
    endcase
  endtask

  task automatic set_voice(input logic [63:0] pat, input logic voiced,
                           input logic [7:0] prd, input logic [4:0] dep);
    write_reg(CFG_DELTA_PATTERN, pat);
    write_reg(CFG_VOICED_MODE, {63'd0, voiced});
    write_reg(CFG_PITCH_PERIOD, {56'd0, prd});
    write_reg(CFG_DELTA_DEPTH, {59'd0, dep});
  endtask

  task automatic add_beat(input logic restart);
    pending.push_back(restart);
    beats_left++;
  endtask

  // registers only change with nothing queued, on the bus or in flight
  task automatic wait_drained();
    do @(posedge clk); while (beats_left != 0 || level_expect.size() != 0);
  endtask

  initial begin : stimulus
    logic [63:0] pat;
    logic [7:0]  prd;
    logic [4:0]  dep;
    int unsigned n;
    int unsigned total;
    pat_cfg    = PATTERN_RST;
    voiced_cfg = 1'b1;
    period_cfg = PERIOD_RST;
    depth_cfg  = DEPTH_FULL;
    lfsr       = NOISE_SEED;
    voice_clear();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // all deltas 3: climbs into the clamp at 15, then the mirrored quarter falls
    set_voice(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 8'd255, DEPTH_FULL);
    repeat (12) add_beat(1'b0);
    add_beat(1'b1);
    wait_drained();

    // noise deltas, period 0 wraps every tick, depth 0 kills every step
    send_pace = PACE_HEAVY;
    recv_pace = PACE_HEAVY;
    set_voice(64'd0, 1'b0, 8'd0, 5'd0);
    add_beat(1'b1);
    repeat (2) add_beat(1'b0);
    wait_drained();

    // period 1, depth above 16 stays unscaled
    send_pace = PACE_LIGHT;
    recv_pace = PACE_FULL;
    set_voice({$urandom, $urandom}, 1'b1, 8'd1, 5'd31);
    repeat (3) add_beat(1'b0);
    wait_drained();

    // short period 3, depth 15 rounding, each period plays deltas 0, 1, 2 before the wrap
    send_pace = PACE_FULL;
    recv_pace = PACE_HEAVY;
    set_voice(64'h1B1B_1B1B_E4E4_E4E4, 1'b1, 8'd3, 5'd15);
    repeat (4) add_beat(1'b0);
    wait_drained();

    // random phases: fresh registers and pacing each time, rare restarts
    total = 0;
    while (total < RANDOM_BEATS) begin
      send_pace = pace_t'($urandom_range(0, 2));
      recv_pace = pace_t'($urandom_range(0, 2));
      case ($urandom_range(0, 3))
        0:       pat = {32{2'($urandom)}};
        1:       pat = ($urandom_range(0, 1) != 0) ? '1 : '0;
        default: pat = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 9))
        0:       prd = 8'($urandom_range(0, 3));
        1:       prd = 8'($urandom_range(128, 255));
        default: prd = 8'($urandom_range(4, 40));
      endcase
      case ($urandom_range(0, 5))
        0:       dep = 5'($urandom_range(17, 31));
        1, 2:    dep = 5'($urandom_range(0, 15));
        default: dep = DEPTH_FULL;
      endcase
      set_voice(pat, 1'($urandom_range(0, 1)), prd, dep);
      n = $urandom_range(25, 50);
      repeat (n) add_beat($urandom_range(0, 19) == 0);
      total += n;
      wait_drained();
    end

    // let any stray result beat show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (level_expect.size() != 0) begin
      $error("%0d expected result beats never arrived", level_expect.size());
      mismatches++;
    end
    if (mismatches == 0) $display("delta_modulation_voice_core: match");
    else $display("delta_modulation_voice_core: mismatch");
    $finish;
  end

endmodule
